@@ rtl/touch_frame_deframer_unit_defines.svh @@
// Assertion macros for the touch frame deframer.
// Used by the top level only; the macros expect i_clk, i_rst_n and o_out_valid in scope.
`ifndef TOUCH_FRAME_DEFRAMER_UNIT_DEFINES_SVH
`define TOUCH_FRAME_DEFRAMER_UNIT_DEFINES_SVH

// Generic clocked implication, switched off while reset is held.
`define TFD_ASSERT_ON(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// A check on the result transaction currently presented.
`define TFD_ASSERT_OUT(label, cons, msg) \
    `TFD_ASSERT_ON(label, o_out_valid, cons, msg)

`endif

@@ rtl/tfd_pkg.sv @@
// Shared constants and types for the touch frame deframer.
// No dependencies; imported by tfd_parser and touch_frame_deframer_unit.
package tfd_pkg;

    // Longest frame accepted; format B frames above this are aborted.
    localparam int unsigned MAX_FRAME_LEN = 64;
    localparam int unsigned CNT_W         = $clog2(MAX_FRAME_LEN + 1);
    localparam int unsigned POS_W         = 6;
    localparam int unsigned TOTAL_W       = 17;

    localparam logic [7:0] HDR_A0   = 8'h55;
    localparam logic [7:0] HDR_A1   = 8'hAA;
    localparam logic [7:0] HDR_A2   = 8'h80;
    localparam logic [7:0] TYPE_A12 = 8'h07;
    localparam logic [7:0] TYPE_A18 = 8'h0D;
    localparam logic [7:0] HDR_B0   = 8'h1F;
    localparam logic [7:0] HDR_B1   = 8'hF7;

    localparam int unsigned LEN_A12    = 12;
    localparam int unsigned LEN_A18    = 18;
    localparam int unsigned B_OVERHEAD = 5;

    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_A12     = 3'd1,
        EV_A18     = 3'd2,
        EV_B       = 3'd3,
        EV_BADSUM  = 3'd4,
        EV_TOOLONG = 3'd5
    } t_event;

    typedef struct packed {
        logic             in_frame;
        logic [POS_W-1:0] pos;
        t_event           event_code;
    } t_result;

endpackage

@@ rtl/tfd_parser.sv @@
// Frame hunting state machine of the touch frame deframer.
// Depends on tfd_pkg; computes one result per stepped byte and updates the parse state.
module tfd_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [7:0]       i_byte,
    output tfd_pkg::t_result o_res
);
    import tfd_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_A1   = 3'd1,
        PH_A2   = 3'd2,
        PH_A3   = 3'd3,
        PH_B1   = 3'd4,
        PH_RA   = 3'd5,
        PH_RB   = 3'd6
    } t_phase;

    t_phase           r_phase, n_phase;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_flen,  n_flen;
    logic [7:0]       r_sum,   n_sum;
    logic [7:0]       r_lo,    n_lo;

    // Outcome of examining the byte afresh from idle.
    t_phase           id_phase;
    logic [CNT_W-1:0] id_count;
    logic [7:0]       id_sum;
    logic             id_in;

    logic [CNT_W:0]     cnt_inc;
    logic               last_byte;
    logic [TOTAL_W-1:0] b_total;
    logic [POS_W-1:0]   cur_pos;
    t_result            res;

    assign cnt_inc   = {1'b0, r_count} + 1'b1;
    assign last_byte = cnt_inc >= {1'b0, r_flen};
    assign b_total   = TOTAL_W'({i_byte, r_lo}) + TOTAL_W'(B_OVERHEAD);
    assign cur_pos   = r_count[POS_W-1:0];

    always_comb begin
        id_phase = PH_IDLE;
        id_count = '0;
        id_sum   = '0;
        id_in    = 1'b0;
        if (i_byte == HDR_A0) begin
            id_phase = PH_A1;
            id_count = CNT_W'(1);
            id_sum   = i_byte;
            id_in    = 1'b1;
        end else if (i_byte == HDR_B0) begin
            id_phase = PH_B1;
            id_count = CNT_W'(1);
            id_sum   = i_byte;
            id_in    = 1'b1;
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        n_flen  = r_flen;
        n_sum   = r_sum;
        n_lo    = r_lo;
        res     = '{in_frame: 1'b0, pos: '0, event_code: EV_NONE};

        case (r_phase)
            PH_A1, PH_A2, PH_B1: begin
                if ((r_phase == PH_A1 && i_byte == HDR_A1) ||
                    (r_phase == PH_A2 && i_byte == HDR_A2) ||
                    (r_phase == PH_B1 && i_byte == HDR_B1)) begin
                    res.in_frame = 1'b1;
                    res.pos      = cur_pos;
                    n_sum        = r_sum + i_byte;
                    n_count      = cnt_inc[CNT_W-1:0];
                    case (r_phase)
                        PH_A1:   n_phase = PH_A2;
                        PH_A2:   n_phase = PH_A3;
                        default: begin
                            n_phase = PH_RB;
                            n_flen  = '0;
                        end
                    endcase
                end else begin
                    n_phase      = id_phase;
                    n_count      = id_count;
                    n_sum        = id_sum;
                    res.in_frame = id_in;
                end
            end
            PH_A3: begin
                if (i_byte == TYPE_A12 || i_byte == TYPE_A18) begin
                    res.in_frame = 1'b1;
                    res.pos      = cur_pos;
                    n_sum        = r_sum + i_byte;
                    n_count      = cnt_inc[CNT_W-1:0];
                    n_phase      = PH_RA;
                    n_flen       = (i_byte == TYPE_A12) ? CNT_W'(LEN_A12) : CNT_W'(LEN_A18);
                end else begin
                    n_phase      = id_phase;
                    n_count      = id_count;
                    n_sum        = id_sum;
                    res.in_frame = id_in;
                end
            end
            PH_RA: begin
                res.in_frame = 1'b1;
                res.pos      = cur_pos;
                if (last_byte) begin
                    if (i_byte != r_sum) begin
                        res.event_code = EV_BADSUM;
                    end else if (r_flen == CNT_W'(LEN_A12)) begin
                        res.event_code = EV_A12;
                    end else begin
                        res.event_code = EV_A18;
                    end
                    n_phase = PH_IDLE;
                    n_count = '0;
                    n_sum   = '0;
                end else begin
                    n_sum   = r_sum + i_byte;
                    n_count = cnt_inc[CNT_W-1:0];
                end
            end
            PH_RB: begin
                res.in_frame = 1'b1;
                res.pos      = cur_pos;
                if (r_count == CNT_W'(2)) begin
                    n_lo    = i_byte;
                    n_sum   = r_sum + i_byte;
                    n_count = cnt_inc[CNT_W-1:0];
                end else if (r_count == CNT_W'(3)) begin
                    if (b_total > TOTAL_W'(MAX_FRAME_LEN)) begin
                        res.event_code = EV_TOOLONG;
                        n_phase        = PH_IDLE;
                        n_count        = '0;
                        n_sum          = '0;
                    end else begin
                        n_flen  = b_total[CNT_W-1:0];
                        n_sum   = r_sum + i_byte;
                        n_count = cnt_inc[CNT_W-1:0];
                    end
                end else if (r_count >= CNT_W'(4) && last_byte) begin
                    res.event_code = (i_byte == r_sum) ? EV_B : EV_BADSUM;
                    n_phase        = PH_IDLE;
                    n_count        = '0;
                    n_sum          = '0;
                end else begin
                    n_sum   = r_sum + i_byte;
                    n_count = cnt_inc[CNT_W-1:0];
                end
            end
            default: begin
                n_phase      = id_phase;
                n_count      = id_count;
                n_sum        = id_sum;
                res.in_frame = id_in;
            end
        endcase
    end

    assign o_res = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_count <= '0;
            r_flen  <= '0;
            r_sum   <= '0;
            r_lo    <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_flen  <= n_flen;
            r_sum   <= n_sum;
            r_lo    <= n_lo;
        end
    end

endmodule

@@ rtl/touch_frame_deframer_unit.sv @@
// Top level of the touch frame deframer: input register, parser, result register.
// Depends on tfd_pkg, tfd_parser and touch_frame_deframer_unit_defines.svh.

// The deframer takes one received byte per input transaction and returns exactly one
// result transaction per byte: the byte itself, a flag saying whether it was taken into
// a frame, its position within that frame (low six bits) and a completion code. It hunts
// for format A frames (55 AA 80 followed by type 07 for twelve bytes or 0D for eighteen)
// and format B frames (1F F7 followed by a little-endian payload length, total length
// being that length plus five). The final byte of a frame must equal the eight-bit sum of
// all earlier bytes. A format B total length beyond MAX_FRAME_LEN aborts the frame on
// its high length byte. A byte that breaks a header is re-examined from idle and may
// start a new frame. Sustained throughput is one byte per clock cycle while results
// are being taken. An accepted byte waits in the input register, and the parser's
// next-state logic between the two registers writes its result into the result
// register when the parser steps. While a finished result waits, the input side still
// accepts a byte as long as the input register is empty.
`include "touch_frame_deframer_unit_defines.svh"

module touch_frame_deframer_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [7:0]                i_rx_byte,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [7:0]                o_data_byte,
    output logic                      o_in_frame,
    output logic [tfd_pkg::POS_W-1:0] o_byte_pos,
    output logic [2:0]                o_frame_event
);
    import tfd_pkg::*;

    // Input register holding a byte waiting for the parser.
    logic       r_in_vld;
    logic [7:0] r_in_byte;

    // Result register presented on the output channel.
    logic             r_out_vld;
    logic [7:0]       r_out_byte;
    t_result          r_out_res;

    logic    step;
    t_result step_res;

    // The parser steps when a byte is waiting and the result register is free or
    // being emptied in this same cycle.
    assign step       = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || step;

    tfd_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (r_in_byte),
        .o_res   (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end
            if (step) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset; their valid flags above qualify them.
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_rx_byte;
        end
        if (step) begin
            r_out_byte <= r_in_byte;
            r_out_res  <= step_res;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_data_byte   = r_out_byte;
    assign o_in_frame    = r_out_res.in_frame;
    assign o_byte_pos    = r_out_res.pos;
    assign o_frame_event = r_out_res.event_code;

    // A completion code is only ever raised on a byte belonging to a frame.
    `TFD_ASSERT_OUT(a_event_in_frame, (o_frame_event == EV_NONE) || o_in_frame,
                    "event outside frame")
    // Bytes outside a frame report position zero.
    `TFD_ASSERT_OUT(a_pos_outside, o_in_frame || (o_byte_pos == '0),
                    "position set outside frame")
    // The first byte of a frame is always a header start byte.
    `TFD_ASSERT_ON(a_frame_start, o_out_valid && o_in_frame && (o_byte_pos == '0),
                   (o_data_byte == HDR_A0) || (o_data_byte == HDR_B0),
                   "frame starts on a non-header byte")
    // Format A completions land on the twelfth or eighteenth byte.
    `TFD_ASSERT_OUT(a_a_length,
                    ((o_frame_event != EV_A12) || (o_byte_pos == POS_W'(LEN_A12 - 1))) &&
                    ((o_frame_event != EV_A18) || (o_byte_pos == POS_W'(LEN_A18 - 1))),
                    "format A frame ends at wrong position")

endmodule

@@ tb/tb_touch_frame_deframer_unit.sv @@
// Self-checking testbench for touch_frame_deframer_unit: frame hunting, checksums, length limit.
// Depends on tfd_pkg and the deframer RTL; a built-in predictor supplies every expected result.
module tb_touch_frame_deframer_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import tfd_pkg::*;

    // Run-length guards. The drain period after the last expected result lets any stray
    // transaction show up before the run ends.
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned HOLD_CYCLES  = 60;

    // Phases of the predictor's header hunt; code 7 is never used.
    typedef enum logic [2:0] {
        HUNT,
        SAW_55,
        SAW_55AA,
        SAW_55AA80,
        SAW_1F,
        BODY_A,
        BODY_B
    } t_hunt_state;

    // Shapes of byte sequence that the random traffic is built from.
    typedef enum {
        KIND_A12,
        KIND_A18,
        KIND_B,
        KIND_B_LONG,
        KIND_NOISE,
        KIND_BROKEN
    } t_frame_kind;

    // One result transaction as the block should present it.
    typedef struct packed {
        logic [7:0]       data;
        logic             in_frame;
        logic [POS_W-1:0] pos;
        t_event           ev;
    } t_echo;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_ready;
    logic [7:0]       i_rx_byte;
    logic             o_out_valid;
    logic             i_out_ready;
    logic [7:0]       o_data_byte;
    logic             o_in_frame;
    logic [POS_W-1:0] o_byte_pos;
    logic [2:0]       o_frame_event;

    // Predictor state, mirroring what the block must hold between bytes.
    t_hunt_state hunt_state = HUNT;
    int unsigned taken      = 0;
    int unsigned frame_len  = 0;
    logic [7:0]  run_sum    = 8'h00;
    logic [7:0]  len_lo     = 8'h00;

    t_echo       expected_echoes[$];
    int unsigned items_sent   = 0;
    int unsigned failures     = 0;
    int unsigned cycle_count  = 0;
    bit          idling       = 1'b1;
    bit          hold_request = 1'b0;

    touch_frame_deframer_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_rx_byte    (i_rx_byte),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_data_byte  (o_data_byte),
        .o_in_frame   (o_in_frame),
        .o_byte_pos   (o_byte_pos),
        .o_frame_event(o_frame_event)
    );

    always #10 i_clk = ~i_clk;

    // ------------------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------------------

    // Take a byte into the current frame without ending it.
    function automatic void absorb(input logic [7:0] b, inout t_echo e);
        e.in_frame = 1'b1;
        e.pos      = taken[POS_W-1:0];
        run_sum    = run_sum + b;
        taken      = taken + 1;
    endfunction

    function automatic void back_to_hunt();
        hunt_state = HUNT;
        taken      = 0;
        run_sum    = 8'h00;
    endfunction

    // Look at a byte as though nothing had been seen; it may open a new frame at position 0.
    function automatic void rehunt(input logic [7:0] b, inout t_echo e);
        back_to_hunt();
        if (b == HDR_A0) begin
            absorb(b, e);
            hunt_state = SAW_55;
        end else if (b == HDR_B0) begin
            absorb(b, e);
            hunt_state = SAW_1F;
        end
    endfunction

    // The last byte of a frame carries the 8-bit sum of everything before it.
    function automatic void close_frame(input logic [7:0] b, input t_event ok_ev,
                                        inout t_echo e);
        e.in_frame = 1'b1;
        e.pos      = taken[POS_W-1:0];
        e.ev       = (b == run_sum) ? ok_ev : EV_BADSUM;
        back_to_hunt();
    endfunction

    function automatic t_echo predict_echo(input logic [7:0] b);
        t_echo       e;
        int unsigned total;
        e.data     = b;
        e.in_frame = 1'b0;
        e.pos      = '0;
        e.ev       = EV_NONE;
        case (hunt_state)
            SAW_55: begin
                if (b == HDR_A1) begin
                    absorb(b, e);
                    hunt_state = SAW_55AA;
                end else begin
                    rehunt(b, e);
                end
            end
            SAW_55AA: begin
                if (b == HDR_A2) begin
                    absorb(b, e);
                    hunt_state = SAW_55AA80;
                end else begin
                    rehunt(b, e);
                end
            end
            SAW_55AA80: begin
                if (b == TYPE_A12) begin
                    absorb(b, e);
                    frame_len  = LEN_A12;
                    hunt_state = BODY_A;
                end else if (b == TYPE_A18) begin
                    absorb(b, e);
                    frame_len  = LEN_A18;
                    hunt_state = BODY_A;
                end else begin
                    rehunt(b, e);
                end
            end
            SAW_1F: begin
                if (b == HDR_B1) begin
                    absorb(b, e);
                    frame_len  = 0;
                    hunt_state = BODY_B;
                end else begin
                    rehunt(b, e);
                end
            end
            BODY_A: begin
                if (taken + 1 >= frame_len) begin
                    close_frame(b, (frame_len == LEN_A12) ? EV_A12 : EV_A18, e);
                end else begin
                    absorb(b, e);
                end
            end
            BODY_B: begin
                if (taken == 2) begin
                    len_lo = b;
                    absorb(b, e);
                end else if (taken == 3) begin
                    // Full-width sum: a payload length near 0xFFFF must not wrap round.
                    total = {b, len_lo} + B_OVERHEAD;
                    absorb(b, e);
                    if (total > MAX_FRAME_LEN) begin
                        e.ev = EV_TOOLONG;
                        back_to_hunt();
                    end else begin
                        frame_len = total;
                    end
                end else if (taken >= 4 && taken + 1 >= frame_len) begin
                    close_frame(b, EV_B, e);
                end else begin
                    absorb(b, e);
                end
            end
            default: rehunt(b, e);
        endcase
        return e;
    endfunction

    // ------------------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------------------

    // Offer one byte and wait for its transaction. Valid is held high across back-to-back
    // bytes; a random gap is only inserted while idling is enabled.
    task automatic send_byte(input logic [7:0] b);
        if (idling && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (!o_in_ready);
        expected_echoes.push_back(predict_echo(b));
        items_sent++;
    endtask

    // Build and send one byte sequence. plen is the payload length for the format B kinds.
    task automatic send_frame(input t_frame_kind kind, input logic [15:0] plen,
                              input bit bad_sum);
        logic [7:0]  bytes[$];
        logic [7:0]  sum;
        int unsigned len;
        int unsigned n;
        sum = 8'h00;
        len = 0;
        case (kind)
            KIND_A12: begin
                bytes = '{HDR_A0, HDR_A1, HDR_A2, TYPE_A12};
                len   = LEN_A12;
            end
            KIND_A18: begin
                bytes = '{HDR_A0, HDR_A1, HDR_A2, TYPE_A18};
                len   = LEN_A18;
            end
            KIND_B: begin
                bytes = '{HDR_B0, HDR_B1, plen[7:0], plen[15:8]};
                len   = plen + B_OVERHEAD;
            end
            KIND_B_LONG: begin
                // The frame is given up on the high length byte, so nothing follows.
                bytes = '{HDR_B0, HDR_B1, plen[7:0], plen[15:8]};
            end
            KIND_NOISE: begin
                n = $urandom_range(1, 4);
                repeat (n) bytes.push_back(8'($urandom_range(0, 255)));
            end
            default: begin
                // A header cut short by an arbitrary byte.
                n = $urandom_range(0, 3);
                if (n == 0) begin
                    bytes = '{HDR_B0};
                end else begin
                    bytes = '{HDR_A0, HDR_A1, HDR_A2};
                    bytes = bytes[0:n-1];
                end
                bytes.push_back(8'($urandom_range(0, 255)));
            end
        endcase
        if (len != 0) begin
            while (bytes.size() < len - 1) bytes.push_back(8'($urandom_range(0, 255)));
            foreach (bytes[i]) sum = sum + bytes[i];
            bytes.push_back(bad_sum ? (sum ^ 8'($urandom_range(1, 255))) : sum);
        end
        foreach (bytes[i]) send_byte(bytes[i]);
    endtask

    // Mostly well-formed random frames, the rest overlong B frames, noise and cut-off headers.
    task automatic send_random_frame();
        int unsigned pick;
        logic [15:0] plen;
        bit          bad;
        pick = $urandom_range(0, 99);
        bad  = ($urandom_range(0, 7) == 0);
        if ($urandom_range(0, 7) == 0) begin
            plen = 16'($urandom_range(0, MAX_FRAME_LEN - B_OVERHEAD));
        end else begin
            plen = 16'($urandom_range(0, 12));
        end
        if (pick < 28) begin
            send_frame(KIND_A12, plen, bad);
        end else if (pick < 50) begin
            send_frame(KIND_A18, plen, bad);
        end else if (pick < 78) begin
            send_frame(KIND_B, plen, bad);
        end else if (pick < 85) begin
            if ($urandom_range(0, 1) == 0) begin
                plen = 16'($urandom_range(MAX_FRAME_LEN - B_OVERHEAD + 1, MAX_FRAME_LEN));
            end else begin
                plen = 16'($urandom_range(MAX_FRAME_LEN, 16'hFFFF));
            end
            send_frame(KIND_B_LONG, plen, bad);
        end else if (pick < 93) begin
            send_frame(KIND_NOISE, plen, bad);
        end else begin
            send_frame(KIND_BROKEN, plen, bad);
        end
    endtask

    // Stop offering bytes until every outstanding result has been returned. The queue is
    // examined on the falling edge so that it never races with the checker.
    task automatic wait_for_echoes();
        i_in_valid <= 1'b0;
        while (expected_echoes.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------------------------

    // The receiver stalls in short random bursts while idling is enabled, or for one long
    // stretch on request so that the block fills and must refuse input.
    initial begin : receiver
        int unsigned stalled;
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request <= 1'b0;
                i_out_ready  <= 1'b0;
                stalled = 0;
                while (stalled < HOLD_CYCLES) begin
                    @(posedge i_clk);
                    stalled++;
                end
                i_out_ready <= 1'b1;
            end else if (idling && $urandom_range(0, 4) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Every result transaction is matched against the oldest expectation, field by field.
    always @(posedge i_clk) begin : check_results
        t_echo want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_echoes.size() == 0) begin
                if (failures < 10) begin
                    $display("unexpected result: byte %02h in_frame %0d pos %0d event %0d",
                             o_data_byte, o_in_frame, o_byte_pos, o_frame_event);
                end
                failures++;
            end else begin
                want = expected_echoes.pop_front();
                if (o_data_byte !== want.data || o_in_frame !== want.in_frame
                        || o_byte_pos !== want.pos || o_frame_event !== want.ev) begin
                    if (failures < 10) begin
                        $display({"mismatch: expected byte %02h in_frame %0d pos %0d ",
                                  "event %0d, got byte %02h in_frame %0d pos %0d event %0d"},
                                 want.data, want.in_frame, want.pos, want.ev,
                                 o_data_byte, o_in_frame, o_byte_pos, o_frame_event);
                    end
                    failures++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------------------

    // The extremes of the byte range, neither of which can open a frame.
    task automatic test_bytes_outside_frames();
        send_byte(8'h00);
        send_byte(8'hFF);
    endtask

    // A format A header broken at its type byte, then a lone 1F that the next 1F breaks;
    // the breaking byte must be looked at afresh and open the following frame.
    task automatic test_broken_headers();
        send_byte(HDR_A0);
        send_byte(HDR_A1);
        send_byte(HDR_A2);
        send_byte(8'h42);
        send_byte(HDR_B0);
    endtask

    // Shortest format B frame with a good and a bad checksum, a length just past the limit,
    // and the largest length, whose sum with the overhead must not wrap.
    task automatic test_format_b_limits();
        send_frame(KIND_B, 16'd0, 1'b0);
        send_frame(KIND_B, 16'd0, 1'b1);
        send_frame(KIND_B_LONG, 16'(MAX_FRAME_LEN - B_OVERHEAD + 1), 1'b0);
        send_frame(KIND_B_LONG, 16'hFFFF, 1'b0);
    endtask

    task automatic test_random_frames(input int unsigned count);
        int unsigned start;
        start = items_sent;
        while (items_sent - start < count) send_random_frame();
    endtask

    // The receiver holds off for a long stretch while bytes keep being offered.
    task automatic test_receiver_hold();
        int unsigned start;
        hold_request <= 1'b1;
        start = items_sent;
        while (items_sent - start < 40) send_random_frame();
    endtask

    // The sender falls silent until the block has returned everything, several times over.
    task automatic test_sender_pause();
        repeat (4) begin
            send_random_frame();
            wait_for_echoes();
        end
    endtask

    // Back-to-back transactions on both sides with no idling at all.
    task automatic test_full_rate();
        idling <= 1'b0;
        test_random_frames(150);
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_rx_byte  = 8'h00;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_bytes_outside_frames();
        test_broken_headers();
        test_format_b_limits();
        test_random_frames(300);
        test_receiver_hold();
        test_sender_pause();
        test_random_frames(150);
        test_full_rate();

        wait_for_echoes();
        if (failures == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
